@@ src/cqdp_pkg.sv @@
// ============================================================================
// cqdp_pkg - shared types and constants of the codebook dot product block
// Payload structs, request codes, register indices and the command and
// status groups between controller and datapath.
// ============================================================================
package cqdp_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [1:0] FUNC_CODEBOOK = 2'd0;
    localparam logic [1:0] FUNC_QUERY    = 2'd1;
    localparam logic [1:0] FUNC_KEY      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_BITS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_LOG2  = 2'd1;

    localparam logic [2:0] CODE_BITS_2     = 3'd2;
    localparam logic [2:0] CODE_BITS_3     = 3'd3;
    localparam logic [2:0] CODE_BITS_RESET = 3'd4;
    localparam logic [3:0] DIM_LOG2_RESET  = 4'd8;
    localparam logic [3:0] DIM_LOG2_MIN    = 4'd3;
    localparam logic [5:0] SHIFT_BASE      = 6'd20;

    localparam logic signed [31:0] LOGIT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] LOGIT_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [1:0]         func;
        logic [7:0]         index;
        logic signed [15:0] value;
        logic [7:0]         key_byte;
        logic [15:0]        scale;
        logic               new_batch;
    } t_in;

    typedef struct packed {
        logic signed [31:0] logit;
        logic [15:0]        key_index;
    } t_out;

    typedef struct packed {
        logic       load_cb;
        logic       load_q;
        logic       load_key;
        logic       issue;
        logic [1:0] step;
        logic       byte_end;
        logic       mul;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] last_step;
        logic       key_done;
    } t_sts;

endpackage

@@ src/cqdp_datapath.sv @@
// ============================================================================
// cqdp_datapath - stores, index unpacking, multiply-accumulate and scaling
// Codebook and query memories, one index per cycle while a key byte issues,
// through a three stage read / multiply / accumulate pipe, then a split
// scale multiply, floor shift and saturation into the output register.
// ============================================================================
module cqdp_datapath import cqdp_pkg::*; #(
    parameter int MAX_DIM   = 256,
    parameter int MAX_CODES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in                   i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    output t_out                  o_out
);

    localparam int LOG_MAX = $clog2(MAX_DIM + 1) - 1;
    localparam int ELEM_W  = LOG_MAX + 1;
    localparam int QA      = $clog2(MAX_DIM);
    localparam int CA      = $clog2(MAX_CODES);

    typedef enum logic [1:0] {MODE_2B, MODE_3B, MODE_4B} t_mode;

    logic signed [15:0] r_cb_mem [MAX_CODES];
    logic signed [15:0] r_q_mem  [MAX_DIM];

    logic [2:0]         r_code_bits;
    logic [3:0]         r_dim_log2;
    logic [7:0]         r_byte;
    logic [15:0]        r_scale;
    logic [1:0]         r_phase;
    logic [1:0]         r_carry;
    logic [ELEM_W-1:0]  r_elem;
    logic [15:0]        r_key_cnt;
    logic signed [47:0] r_acc;
    logic signed [15:0] r_cb_rd;
    logic signed [15:0] r_q_rd;
    logic               r_code_ok;
    logic               r_v1;
    logic signed [31:0] r_mul;
    logic               r_v2;
    logic [39:0]        r_pp_lo;
    logic signed [39:0] r_pp_hi;
    t_out               r_out;

    t_mode              w_mode;
    logic               w_clear;
    logic [3:0]         w_code;
    logic [2:0]         w_sh2;
    logic [9:0]         w_buf;
    logic [3:0]         w_base3;
    logic [3:0]         w_sh3;
    logic [3:0]         w_e;
    logic [ELEM_W-1:0]  w_dim;
    logic [5:0]         w_sh;
    logic signed [15:0] w_cb;
    logic signed [40:0] w_pp_hi;
    logic [39:0]        w_pp_lo;
    logic signed [63:0] w_full;
    logic signed [63:0] w_shr;
    logic signed [31:0] w_logit;
    logic [1:0]         n_carry;
    logic [1:0]         n_phase;
    logic signed [47:0] n_acc;

    always_comb begin
        case (r_code_bits)
            CODE_BITS_2: w_mode = MODE_2B;
            CODE_BITS_3: w_mode = MODE_3B;
            default:     w_mode = MODE_4B;
        endcase
    end

    assign w_clear = i_cmd.out_load ||
                     (i_cfg_we && (i_cfg_index == REG_CODE_BITS ||
                                   i_cfg_index == REG_DIM_LOG2));

    // index unpacking, most significant bits first
    assign w_sh2 = 3'd6 - {i_cmd.step, 1'b0};
    assign w_buf = {r_carry, r_byte};

    always_comb begin
        case (r_phase)
            2'd0:    w_base3 = 4'd5;
            2'd1:    w_base3 = 4'd7;
            default: w_base3 = 4'd6;
        endcase
        w_sh3 = w_base3 - ({2'b00, i_cmd.step} + {1'b0, i_cmd.step, 1'b0});
    end

    always_comb begin
        case (w_mode)
            MODE_2B: w_code = {2'b00, 2'(r_byte >> w_sh2)};
            MODE_3B: w_code = {1'b0, 3'(w_buf >> w_sh3)};
            default: w_code = i_cmd.step[0] ? r_byte[3:0] : r_byte[7:4];
        endcase
    end

    always_comb begin
        case (w_mode)
            MODE_2B: o_sts.last_step = 2'd3;
            MODE_3B: o_sts.last_step = (r_phase == 2'd0) ? 2'd1 : 2'd2;
            default: o_sts.last_step = 2'd1;
        endcase
    end

    always_comb begin
        case (r_phase)
            2'd0:    n_carry = r_byte[1:0];
            2'd1:    n_carry = {1'b0, r_byte[0]};
            default: n_carry = 2'd0;
        endcase
        n_phase = (r_phase == 2'd2) ? 2'd0 : r_phase + 2'd1;
    end

    // effective key length
    always_comb begin
        if (r_dim_log2 < DIM_LOG2_MIN) begin
            w_e = DIM_LOG2_MIN;
        end else if (r_dim_log2 > 4'(LOG_MAX)) begin
            w_e = 4'(LOG_MAX);
        end else begin
            w_e = r_dim_log2;
        end
    end

    assign w_dim          = {{(ELEM_W-1){1'b0}}, 1'b1} << w_e;
    assign o_sts.key_done = (r_elem >= w_dim);
    assign w_sh           = SHIFT_BASE + {2'b00, w_e};

    assign w_cb  = r_code_ok ? r_cb_rd : 16'sd0;
    assign n_acc = r_acc + {{16{r_mul[31]}}, r_mul};

    // scale multiply split into two partial products
    assign w_pp_hi = 41'($signed(r_acc[47:24])) * 41'($signed({1'b0, r_scale}));
    assign w_pp_lo = 40'(r_acc[23:0]) * 40'(r_scale);

    assign w_full = $signed({r_pp_hi, 24'b0}) + $signed({24'b0, r_pp_lo});
    assign w_shr  = w_full >>> w_sh;

    always_comb begin
        if ((&w_shr[63:31]) || !(|w_shr[63:31])) begin
            w_logit = w_shr[31:0];
        end else if (w_shr[63]) begin
            w_logit = LOGIT_MIN;
        end else begin
            w_logit = LOGIT_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_cb && int'(i_in.index) < MAX_CODES) begin
            r_cb_mem[CA'(i_in.index)] <= i_in.value;
        end
        if (i_cmd.issue) begin
            r_cb_rd <= r_cb_mem[w_code[CA-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_q && int'(i_in.index) < MAX_DIM) begin
            r_q_mem[QA'(i_in.index)] <= i_in.value;
        end
        if (i_cmd.issue) begin
            r_q_rd <= r_q_mem[r_elem[QA-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_code_bits <= CODE_BITS_RESET;
            r_dim_log2  <= DIM_LOG2_RESET;
            r_phase     <= 2'd0;
            r_carry     <= 2'd0;
            r_elem      <= '0;
            r_key_cnt   <= 16'd0;
            r_acc       <= 48'sd0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
        end else begin
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            if (i_cfg_we && i_cfg_index == REG_CODE_BITS) begin
                r_code_bits <= i_cfg_data[2:0];
            end
            if (i_cfg_we && i_cfg_index == REG_DIM_LOG2) begin
                r_dim_log2 <= i_cfg_data;
            end
            if (w_clear) begin
                r_phase <= 2'd0;
                r_carry <= 2'd0;
                r_elem  <= '0;
                r_acc   <= 48'sd0;
            end else begin
                if (i_cmd.issue) begin
                    r_elem <= r_elem + ELEM_W'(1);
                end
                if (i_cmd.byte_end) begin
                    r_phase <= n_phase;
                    if (w_mode == MODE_3B) begin
                        r_carry <= n_carry;
                    end
                end
                if (r_v2) begin
                    r_acc <= n_acc;
                end
            end
            if (i_cmd.load_key && i_in.new_batch) begin
                r_key_cnt <= 16'd0;
            end else if (i_cmd.out_load) begin
                r_key_cnt <= r_key_cnt + 16'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_byte  <= i_in.key_byte;
            r_scale <= i_in.scale;
        end
        if (i_cmd.issue) begin
            r_code_ok <= int'(w_code) < MAX_CODES;
        end
        r_mul <= 32'(w_cb) * 32'(r_q_rd);
        if (i_cmd.mul) begin
            r_pp_hi <= w_pp_hi[39:0];
            r_pp_lo <= w_pp_lo;
        end
        if (i_cmd.out_load) begin
            r_out.logit     <= w_logit;
            r_out.key_index <= r_key_cnt;
        end
    end

    assign o_out = r_out;

endmodule

@@ src/cqdp_ctrl.sv @@
// ============================================================================
// cqdp_ctrl - request sequencer of the codebook dot product block
// Takes requests, steps through the indices of a key byte, waits for the
// accumulate pipe to drain and runs the final scale on a completed key.
// ============================================================================
module cqdp_ctrl import cqdp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_func,
    output logic       o_in_ready,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd,
    input  t_sts       i_sts
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ISSUE = 5'b00010,
        S_DRAIN = 5'b00100,
        S_MUL   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    logic [1:0] r_step;
    logic [1:0] n_step;
    logic       r_drain;
    logic       n_drain;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_drain     = r_drain;
        o_cmd       = '0;
        o_cmd.step  = r_step;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_func)
                        FUNC_CODEBOOK: o_cmd.load_cb = 1'b1;
                        FUNC_QUERY:    o_cmd.load_q  = 1'b1;
                        FUNC_KEY: begin
                            o_cmd.load_key = 1'b1;
                            n_step         = 2'd0;
                            n_state        = S_ISSUE;
                        end
                        default: ;
                    endcase
                end
            end
            S_ISSUE: begin
                o_cmd.issue = 1'b1;
                if (r_step == i_sts.last_step) begin
                    o_cmd.byte_end = 1'b1;
                    n_drain        = 1'b0;
                    n_state        = S_DRAIN;
                end else begin
                    n_step = r_step + 2'd1;
                end
            end
            S_DRAIN: begin
                if (r_drain) begin
                    n_state = i_sts.key_done ? S_MUL : S_IDLE;
                end else begin
                    n_drain = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 2'd0;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_drain     <= n_drain;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ src/codebook_quantized_dot_product.sv @@
// ============================================================================
// codebook_quantized_dot_product - codebook dequantised key dot product
// Dot product of a stored Q1.14 query with keys given as packed 2, 3 or
// 4 bit codebook indices; each completed key gives a saturated Q16.16 logit.
// ============================================================================
//
//  channel   | direction | handshake                | payload
//  ----------+-----------+--------------------------+------------------------
//  request   | in        | i_in_valid / o_in_ready  | i_in  (t_in)
//  result    | out       | o_out_valid / i_out_ready| o_out (t_out)
//  config    | in        | i_cfg_we, no wait        | i_cfg_index, i_cfg_data
//
//  a load request leaves the block ready; a key byte issues its n indices,
//  n being its index count (2, 3 or 4), in turn through the single codebook
//  read port, then drains the pipe; a byte completing a key adds the scale
//  multiply and saturation, and waits while the output register is full
//  a new request is taken while a finished result waits to be taken
//  synchronous active-low reset; stores hold no reset value
//
module codebook_quantized_dot_product import cqdp_pkg::*; #(
    parameter int MAX_DIM   = 256,
    parameter int MAX_CODES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    cqdp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_func      (i_in.func),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    cqdp_datapath #(
        .MAX_DIM   (MAX_DIM),
        .MAX_CODES (MAX_CODES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out       (o_out)
    );

endmodule

@@ src/cqdp_checker.sv @@
// ============================================================================
// cqdp_checker - port level checks of the codebook dot product block
// Result handshake and request sequencing as seen on the top level ports.
// ============================================================================
module cqdp_checker import cqdp_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // a store load request leaves the block ready
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready &&
        (i_in.func == FUNC_CODEBOOK || i_in.func == FUNC_QUERY) |=> o_in_ready)
        else $error("not ready after a load request");

    // a key byte request occupies the block
    a_key_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_in.func == FUNC_KEY |=> !o_in_ready)
        else $error("ready right after a key byte");

    // a new result only comes out of the final scaling step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result raised from idle");

endmodule

bind codebook_quantized_dot_product cqdp_checker u_cqdp_checker (.*);

@@ verif/tb_codebook_quantized_dot_product.sv @@
// ============================================================================
// tb_codebook_quantized_dot_product - self-checking bench of the key dot product
// Fills both stores, then streams directed and random key bytes under several
// code widths and key lengths. Every request is predicted as it is taken;
// each logit is compared with the oldest prediction. Both handshakes stall
// at random.
// ============================================================================
module tb_codebook_quantized_dot_product;
    import cqdp_pkg::*;

    localparam int MAX_DIM      = 256;
    localparam int MAX_CODES    = 16;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [1:0]           FUNC_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;

    class logit_scoreboard;
        logic signed [15:0] query_mem [MAX_DIM];
        logic signed [15:0] codebook_mem [MAX_CODES];
        logic [2:0]         code_bits;
        logic [3:0]         dim_log2;
        longint             dot_sum;
        int unsigned        byte_cnt;
        int unsigned        elem_cnt;
        int unsigned        carry;
        logic [15:0]        key_num;
        t_out               pending_logits [$];
        int unsigned        logits_predicted;
        int unsigned        failures;

        function new();
            code_bits        = CODE_BITS_RESET;
            dim_log2         = DIM_LOG2_RESET;
            key_num          = '0;
            logits_predicted = 0;
            failures         = 0;
            clear_key();
        endfunction

        function void clear_key();
            dot_sum  = 0;
            byte_cnt = 0;
            elem_cnt = 0;
            carry    = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_CODE_BITS) begin
                code_bits = data[2:0];
            end else if (idx == REG_DIM_LOG2) begin
                dim_log2 = data;
            end else begin
                return;
            end
            clear_key();
        endfunction

        function void accumulate(int unsigned code);
            longint cb_val;
            longint q_val;
            cb_val = 0;
            q_val  = 0;
            if (code < MAX_CODES) cb_val = longint'(codebook_mem[code]);
            if (elem_cnt < MAX_DIM) q_val = longint'(query_mem[elem_cnt]);
            dot_sum += cb_val * q_val;
            elem_cnt++;
        endfunction

        function void take_request(t_in r);
            int unsigned nbits;
            int unsigned bits;
            int          eff;
            longint      prod;
            t_out        want;
            if (r.func == FUNC_CODEBOOK) begin
                if (r.index < MAX_CODES) codebook_mem[r.index] = r.value;
                return;
            end
            if (r.func == FUNC_QUERY) begin
                if (r.index < MAX_DIM) query_mem[r.index] = r.value;
                return;
            end
            if (r.func != FUNC_KEY) return;

            if (r.new_batch) key_num = '0;
            if (code_bits == CODE_BITS_2) begin
                for (int k = 3; k >= 0; k--) accumulate(32'((r.key_byte >> (2 * k)) & 8'h03));
            end else if (code_bits == CODE_BITS_3) begin
                // indices run msb first across each byte triple
                case (byte_cnt % 3)
                    0: begin
                        nbits = 8;
                        bits  = 32'(r.key_byte);
                    end
                    1: begin
                        nbits = 10;
                        bits  = ((carry & 3) << 8) | 32'(r.key_byte);
                    end
                    default: begin
                        nbits = 9;
                        bits  = ((carry & 1) << 8) | 32'(r.key_byte);
                    end
                endcase
                while (nbits >= 3) begin
                    accumulate((bits >> (nbits - 3)) & 7);
                    nbits -= 3;
                end
                carry = bits & ((1 << nbits) - 1);
            end else begin
                accumulate(32'(r.key_byte >> 4));
                accumulate(32'(r.key_byte & 8'h0F));
            end
            byte_cnt++;

            eff = int'(dim_log2);
            if (eff < int'(DIM_LOG2_MIN)) eff = int'(DIM_LOG2_MIN);
            while (eff > 0 && (1 << eff) > MAX_DIM) eff--;
            if (elem_cnt < (1 << eff)) return;

            // floor shift, then saturate to the logit range
            prod = dot_sum * longint'({1'b0, r.scale});
            prod = prod >>> (int'(SHIFT_BASE) + eff);
            if (prod > longint'(LOGIT_MAX)) prod = longint'(LOGIT_MAX);
            else if (prod < longint'(LOGIT_MIN)) prod = longint'(LOGIT_MIN);
            want.logit     = prod[31:0];
            want.key_index = key_num;
            pending_logits.push_back(want);
            logits_predicted++;
            key_num++;
            clear_key();
        endfunction

        function void check_logit(t_out got);
            t_out want;
            if (pending_logits.size() == 0) begin
                $error("unexpected result: logit %0d key_index %0d", got.logit, got.key_index);
                failures++;
                return;
            end
            want = pending_logits.pop_front();
            if (got.logit !== want.logit) begin
                $error("logit: expected %0d actual %0d", want.logit, got.logit);
                failures++;
            end
            if (got.key_index !== want.key_index) begin
                $error("key_index: expected %0d actual %0d", want.key_index, got.key_index);
                failures++;
            end
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  req_valid = 1'b0;
    logic                  req_ready;
    t_in                   req       = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b1;
    t_out                  res;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logit_scoreboard sb = new();
    int unsigned     burst_left = 0;
    int unsigned     rx_left    = 0;
    int unsigned     cycles     = 0;

    logic [3:0] phase_code  [0:8] = '{4'd2, 4'd3, 4'd4, 4'd0, 4'd7, 4'hA, 4'd3, 4'd2, 4'd3};
    logic [3:0] phase_dim   [0:8] = '{4'd3, 4'd3, 4'd4, 4'd0, 4'd3, 4'd5, 4'd4, 4'hF, 4'd6};
    int         phase_items [0:8] = '{50, 60, 50, 40, 40, 60, 60, 140, 60};

    codebook_quantized_dot_product #(
        .MAX_DIM   (MAX_DIM),
        .MAX_CODES (MAX_CODES)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_ready  (req_ready),
        .i_in        (req),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // result side: alternating ready and stall stretches
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) sb.check_logit(res);
        if (rx_left == 0) begin
            res_ready <= ~res_ready;
            if (res_ready) rx_left <= $urandom_range(1, 12);
            else if ($urandom_range(0, 7) == 0) rx_left <= 200;
            else rx_left <= $urandom_range(1, 40);
        end else begin
            rx_left <= rx_left - 1;
        end
    end

    function automatic t_in random_request();
        t_in         r;
        int unsigned pick;
        r.func      = FUNC_KEY;
        r.index     = 8'($urandom);
        r.value     = 16'($urandom);
        r.key_byte  = 8'($urandom);
        r.scale     = 16'($urandom);
        r.new_batch = ($urandom_range(0, 11) == 0);
        pick = $urandom_range(0, 7);
        if (pick == 0) r.scale = '0;
        else if (pick == 1) r.scale = '1;
        pick = $urandom_range(0, 99);
        if (pick >= 97) begin
            r.func = FUNC_SPARE;
        end else if (pick >= 91) begin
            r.func = FUNC_CODEBOOK;
            if (pick < 95) r.index = 8'($urandom_range(0, MAX_CODES - 1));
        end else if (pick >= 85) begin
            r.func = FUNC_QUERY;
        end
        return r;
    endfunction

    function automatic t_in key_request(logic [7:0] kb, logic [15:0] scale, logic nb);
        t_in r;
        r           = random_request();
        r.func      = FUNC_KEY;
        r.key_byte  = kb;
        r.scale     = scale;
        r.new_batch = nb;
        return r;
    endfunction

    function automatic t_in load_request(logic [1:0] func, logic [7:0] index,
                                         logic signed [15:0] value);
        t_in r;
        r       = random_request();
        r.func  = func;
        r.index = index;
        r.value = value;
        return r;
    endfunction

    task automatic send_request(input t_in r);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0) begin
                req_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        req       <= r;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        sb.take_request(r);
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending_logits.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_register(idx, data);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic signed [15:0] fill;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill both stores, extremes at the ends
        for (int i = 0; i < MAX_CODES; i++) begin
            fill = 16'($urandom);
            if (i == 0) fill = 16'sh8000;
            if (i == MAX_CODES - 1) fill = 16'sh7FFF;
            send_request(load_request(FUNC_CODEBOOK, 8'(i), fill));
        end
        for (int i = 0; i < MAX_DIM; i++) begin
            fill = 16'($urandom);
            if (i == 0) fill = 16'sh8000;
            if (i == MAX_DIM - 1) fill = 16'sh7FFF;
            send_request(load_request(FUNC_QUERY, 8'(i), fill));
        end

        // full-length keys at the reset setting
        repeat (260) send_request(random_request());

        // directed: 4 bit codes, shortest key, loads in mid-key
        write_register(REG_DIM_LOG2, DIM_LOG2_MIN);
        send_request(key_request(8'hFF, 16'hFFFF, 1'b1));
        send_request(key_request(8'h00, 16'h0000, 1'b0));
        send_request(load_request(FUNC_CODEBOOK, 8'd0, 16'sh8000));
        send_request(load_request(FUNC_QUERY, 8'd1, 16'sh7FFF));
        send_request(key_request(8'hF0, 16'h8000, 1'b0));
        send_request(key_request(8'h0F, 16'hFFFF, 1'b0));
        send_request(load_request(FUNC_CODEBOOK, 8'(MAX_CODES), 16'sh1234));
        send_request(load_request(FUNC_CODEBOOK, 8'hFF, 16'sh7FFF));
        send_request(load_request(FUNC_QUERY, 8'hFF, 16'sh8000));
        send_request(load_request(FUNC_SPARE, 8'h00, 16'sh0000));

        // 2 bit codes
        write_register(REG_CODE_BITS, CODE_BITS_2);
        send_request(key_request(8'hFF, 16'h8000, 1'b1));
        send_request(key_request(8'h00, 16'hFFFF, 1'b0));
        send_request(key_request(8'hAA, 16'h0001, 1'b0));
        send_request(key_request(8'h55, 16'h0000, 1'b0));

        // 3 bit codes across a byte triple, then a key cut short by a write
        write_register(REG_CODE_BITS, CODE_BITS_3);
        send_request(key_request(8'hFF, 16'hFFFF, 1'b0));
        send_request(key_request(8'h00, 16'hFFFF, 1'b0));
        send_request(key_request(8'hA5, 16'hFFFF, 1'b0));
        send_request(key_request(8'h5A, 16'h0100, 1'b1));
        write_register(REG_DIM_LOG2, 4'd0);
        send_request(key_request(8'h36, 16'h0100, 1'b0));
        send_request(key_request(8'hC9, 16'h0100, 1'b0));
        send_request(key_request(8'h24, 16'h0100, 1'b0));
        write_register(REG_SPARE, 4'hF);

        // random phases over code widths and key lengths
        for (int p = 0; p < 9; p++) begin
            write_register(REG_CODE_BITS, phase_code[p]);
            write_register(REG_DIM_LOG2, phase_dim[p]);
            repeat (phase_items[p]) send_request(random_request());
        end
        while (sb.logits_predicted < 60) begin
            write_register(REG_CODE_BITS, 4'($urandom_range(0, 15)));
            write_register(REG_DIM_LOG2, 4'($urandom_range(0, 4)));
            repeat (40) send_request(random_request());
        end

        settle();
        if (sb.failures == 0 && sb.pending_logits.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
